>>> rtl/wfws_pkg.sv
// ----------------------------------------------------------------------------
// wfws_pkg
// Types and constants shared by the wall-follow wheel speed block.
// ----------------------------------------------------------------------------
`default_nettype none
package wfws_pkg;

  localparam int CURV_LIMIT   = 1536;
  localparam int CURV_NO_WALL = 2048;
  localparam int SQ_BITS      = 26;

  localparam logic [2:0] MODE_FOLLOW  = 3'd0;
  localparam logic [2:0] MODE_NO_WALL = 3'd1;
  localparam logic [2:0] MODE_REVERSE = 3'd2;
  localparam logic [2:0] MODE_TURN_R  = 3'd3;
  localparam logic [2:0] MODE_TURN_L  = 3'd4;

  localparam logic [2:0] REG_VALID_MAX = 3'd0;
  localparam logic [2:0] REG_VALID_MIN = 3'd1;
  localparam logic [2:0] REG_OBSTACLE  = 3'd2;
  localparam logic [2:0] REG_TARGET    = 3'd3;
  localparam logic [2:0] REG_BASE      = 3'd4;
  localparam logic [2:0] REG_TURN      = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CURV,
    ST_SCALE,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic curv;
    logic scale;
    logic div_start;
    logic div_step;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

endpackage
`default_nettype wire

>>> rtl/wfws_ctrl.sv
// ----------------------------------------------------------------------------
// wfws_ctrl
// Sequencer: load, curvature, scale, serial divide, finish, output.
// ----------------------------------------------------------------------------
`default_nettype none
module wfws_ctrl
  import wfws_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  output cmd_t         cmd,
  input  wire status_t status
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_CURV;
        end
      end
      ST_CURV: begin
        cmd.curv = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        cmd.div_start = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        in_stall = out_stall;
        if (!out_stall) begin
          if (in_valid) begin
            cmd.load = 1'b1;
            state_next = ST_CURV;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/wfws_dp.sv
// ----------------------------------------------------------------------------
// wfws_dp
// Datapath: validity, curvature, speed ratio by restoring division, override.
// ----------------------------------------------------------------------------
`default_nettype none
module wfws_dp
  import wfws_pkg::*;
#(
  parameter int DIST_BITS       = 12,
  parameter int SPEED_FRAC_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cmd_t                 cmd,
  output status_t                   status,
  input  wire logic [11:0]          valid_max_mm,
  input  wire logic [11:0]          valid_min_mm,
  input  wire logic [11:0]          obstacle_mm,
  input  wire logic [12:0]          wall_sum_target_mm,
  input  wire logic [6:0]           base_speed,
  input  wire logic [6:0]           turn_speed,
  input  wire logic [DIST_BITS-1:0] front_center_mm,
  input  wire logic [DIST_BITS-1:0] front_left_mm,
  input  wire logic [DIST_BITS-1:0] front_right_mm,
  input  wire logic [DIST_BITS-1:0] left_rear_mm,
  input  wire logic [DIST_BITS-1:0] right_front_mm,
  input  wire logic [DIST_BITS-1:0] right_rear_mm,
  output logic signed [15:0]        left_speed,
  output logic signed [15:0]        right_speed,
  output logic [2:0]                drive_mode
);

  localparam int FW = 7 + SPEED_FRAC_BITS + 1;   // full, signed
  localparam int NW = FW + 13;                  // full*num numerator
  localparam int QW = NW;
  localparam int CW = $clog2(QW + 1);
  localparam int NSW = 2*DIST_BITS + 2;         // n sum width
  localparam int TW = 27;                       // clamped n*256+5000

  // per-item registers
  logic                 rf_ok, obst, all_close, go_left;
  logic signed [SQ_BITS-1:0] prev_sq;
  logic signed [NSW+8:0] n_reg;
  logic signed [12:0]    c256;
  logic [NW-1:0]         rem, quo;
  logic [12:0]           den;
  logic [CW-1:0]         cnt;
  logic signed [FW-1:0]  full;

  function automatic logic ok(input logic [DIST_BITS-1:0] r,
                              input logic [11:0] mx, input logic [11:0] mn);
    ok = ({12'd0, r} < {{(DIST_BITS){1'b0}}, mx}) &&
         ({12'd0, r} > {{(DIST_BITS){1'b0}}, mn});
  endfunction

  function automatic logic near(input logic [DIST_BITS-1:0] r,
                                input logic [11:0] mx, input logic [11:0] mn,
                                input logic [11:0] ob);
    near = ok(r, mx, mn) && ({12'd0, r} < {{(DIST_BITS){1'b0}}, ob});
  endfunction

  // load stage: square and linear term
  logic signed [DIST_BITS:0]   diff;
  logic signed [2*DIST_BITS+1:0] sq;
  logic signed [NSW+8:0]       n_c;
  always_comb begin
    diff = $signed({1'b0, right_front_mm}) - $signed({1'b0, right_rear_mm});
    sq = diff * diff;
    if (right_front_mm <= right_rear_mm) sq = -sq;
    n_c = 250 * ($signed({{(NSW+9-DIST_BITS){1'b0}}, right_front_mm})
               + $signed({{(NSW+9-DIST_BITS){1'b0}}, right_rear_mm})
               - $signed({{(NSW-4){1'b0}}, wall_sum_target_mm}))
        + 39 * (NSW+9)'(sq) - 9 * (NSW+9)'(prev_sq);
  end

  // curvature: floor((n*256+5000)/10000) via multiply by reciprocal + fixup;
  // |n| beyond 2^16 always clamps, so n is bounded first
  logic signed [NSW+8:0] n_s;
  logic signed [TW-1:0]  t;
  logic signed [63:0]    prod;
  logic signed [TW-1:0]  qe;
  logic signed [31:0]    r;
  logic signed [TW-1:0]  cq;
  always_comb begin
    if (n_reg > 65535) n_s = (NSW+9)'(65535);
    else if (n_reg < -65536) n_s = -(NSW+9)'(65536);
    else n_s = n_reg;
    t = TW'(n_s * 256 + 5000);
    prod = 64'(t) * 64'sd109951163;
    qe = TW'(prod >>> 40);
    r = 32'(t) - 32'(qe) * 10000;
    cq = qe;
    if (r < 0) cq = qe - 27'sd1;
    else if (r >= 10000) cq = qe + 27'sd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sq <= '0;
    end else if (cmd.load && ok(right_front_mm, valid_max_mm, valid_min_mm)) begin
      prev_sq <= SQ_BITS'(sq);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rf_ok <= ok(right_front_mm, valid_max_mm, valid_min_mm);
      obst <= near(front_center_mm, valid_max_mm, valid_min_mm, obstacle_mm);
      all_close <= near(front_left_mm, valid_max_mm, valid_min_mm, obstacle_mm) &&
                   near(front_right_mm, valid_max_mm, valid_min_mm, obstacle_mm);
      go_left <= !ok(left_rear_mm, valid_max_mm, valid_min_mm) ||
                 (left_rear_mm > right_rear_mm);
      n_reg <= n_c;
      full <= FW'({1'b0, base_speed}) <<< SPEED_FRAC_BITS;
    end
    if (cmd.curv) begin
      if (!rf_ok) c256 <= 13'(CURV_NO_WALL);
      else if (cq > CURV_LIMIT) c256 <= 13'(CURV_LIMIT);
      else if (cq < -CURV_LIMIT) c256 <= -13'(CURV_LIMIT);
      else c256 <= 13'(cq);
    end
  end

  // scale: numerator full*num + den/2, then restoring division
  logic [12:0] num_c, den_c;
  logic [NW:0] trial;
  always_comb begin
    if (c256 > 0) begin
      num_c = 13'd2560;
      den_c = 13'(14'sd5120 - c256);
    end else begin
      num_c = 13'(13'sd2560 + c256);
      den_c = 13'(14'sd5120 + c256);
    end
    trial = {1'b0, rem[NW-2:0], quo[NW-1]} - {{(NW-12){1'b0}}, den};
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      den <= den_c;
      quo <= NW'(full[FW-2:0]) * NW'(num_c) + NW'(den_c >> 1);
      rem <= '0;
      cnt <= CW'(QW - 1);
    end else if (cmd.div_step) begin
      if (!trial[NW]) begin
        rem <= trial[NW-1:0];
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= {rem[NW-2:0], quo[NW-1]};
        quo <= {quo[NW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
    end
  end
  assign status.div_last = (cnt == '0);

  function automatic logic [15:0] sat(input logic signed [FW:0] v);
    if (v > 32767) sat = 16'h7fff;
    else if (v < -32768) sat = 16'h8000;
    else sat = v[15:0];
  endfunction

  logic signed [FW:0] lft, rgt, turn_f, full_x;
  always_comb begin
    full_x = {full[FW-1], full};
    turn_f = (FW+1)'({1'b0, turn_speed}) <<< SPEED_FRAC_BITS;
    lft = $signed({1'b0, quo[FW-1:0]});
    rgt = full_x - lft;
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      if (obst && all_close) begin
        left_speed <= sat(-(full_x >>> 1));
        right_speed <= sat(-(full_x >>> 1));
        drive_mode <= MODE_REVERSE;
      end else if (obst && go_left) begin
        left_speed <= sat(turn_f);
        right_speed <= sat(full_x - turn_f);
        drive_mode <= MODE_TURN_L;
      end else if (obst) begin
        right_speed <= sat(turn_f);
        left_speed <= sat(full_x - turn_f);
        drive_mode <= MODE_TURN_R;
      end else begin
        left_speed <= sat(lft);
        right_speed <= sat(rgt);
        drive_mode <= rf_ok ? MODE_FOLLOW : MODE_NO_WALL;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/wall_follow_wheel_speed.sv
// ----------------------------------------------------------------------------
// wall_follow_wheel_speed
// Right wall following PD steering for a differential drive.
// Input channel: in_valid/in_stall with seven range readings per beat.
// Output channel: out_valid/out_stall with left/right speeds (Q8.8) and mode.
// Config channel: cfg_valid/cfg_ready, cfg_index selects the register;
// writes are taken every cycle, unknown indexes are ignored.
// Each item runs through load, curvature, scale, a bit-serial restoring
// division that forms the left/right speed ratio, finish and output.
// One item is in work at a time; a new item is taken
// in the cycle its predecessor's result is taken.
// While a result waits under out_stall it holds and no new item is accepted.
// Reset clears the sequencer, restores register defaults and clears the
// stored signed square of the previous update.
// ----------------------------------------------------------------------------
`default_nettype none
module wall_follow_wheel_speed
  import wfws_pkg::*;
#(
  parameter int DIST_BITS       = 12,
  parameter int SPEED_FRAC_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [12:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [DIST_BITS-1:0] front_center_mm,
  input  wire logic [DIST_BITS-1:0] front_left_mm,
  input  wire logic [DIST_BITS-1:0] front_right_mm,
  input  wire logic [DIST_BITS-1:0] left_front_mm,
  input  wire logic [DIST_BITS-1:0] left_rear_mm,
  input  wire logic [DIST_BITS-1:0] right_front_mm,
  input  wire logic [DIST_BITS-1:0] right_rear_mm,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [15:0]        left_speed,
  output logic signed [15:0]        right_speed,
  output logic [2:0]                drive_mode
);

  logic [11:0] valid_max_mm, valid_min_mm, obstacle_mm;
  logic [12:0] wall_sum_target_mm;
  logic [6:0]  base_speed, turn_speed;
  cmd_t        cmd;
  status_t     status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_max_mm <= 12'd500;
      valid_min_mm <= 12'd20;
      obstacle_mm <= 12'd200;
      wall_sum_target_mm <= 13'd300;
      base_speed <= 7'd50;
      turn_speed <= 7'd10;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VALID_MAX: valid_max_mm <= cfg_data[11:0];
        REG_VALID_MIN: valid_min_mm <= cfg_data[11:0];
        REG_OBSTACLE:  obstacle_mm <= cfg_data[11:0];
        REG_TARGET:    wall_sum_target_mm <= cfg_data;
        REG_BASE:      base_speed <= cfg_data[6:0];
        REG_TURN:      turn_speed <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  wfws_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .status(status)
  );

  wfws_dp #(.DIST_BITS(DIST_BITS), .SPEED_FRAC_BITS(SPEED_FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .valid_max_mm(valid_max_mm), .valid_min_mm(valid_min_mm),
    .obstacle_mm(obstacle_mm), .wall_sum_target_mm(wall_sum_target_mm),
    .base_speed(base_speed), .turn_speed(turn_speed),
    .front_center_mm(front_center_mm), .front_left_mm(front_left_mm),
    .front_right_mm(front_right_mm), .left_rear_mm(left_rear_mm),
    .right_front_mm(right_front_mm), .right_rear_mm(right_rear_mm),
    .left_speed(left_speed), .right_speed(right_speed), .drive_mode(drive_mode)
  );

  logic unused;
  assign unused = ^left_front_mm;

endmodule
`default_nettype wire

>>> tb/sv/wall_follow_wheel_speed_tb.sv
// ----------------------------------------------------------------------------
// wall_follow_wheel_speed_tb
// Self-checking bench for the wall-follow wheel speed block. A predictor of
// curvature and wheel speeds is fed with every accepted beat and its
// expectations are compared field by field with the results. Directed
// corners, several register settings and random stimulus with random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wall_follow_wheel_speed_tb
  import wfws_pkg::*;
;

  localparam int DB = 12;
  localparam int FB = 8;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [2:0]         mode;
  } speeds_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [DB-1:0] fc = '0, fl = '0, fr = '0, lf = '0, lrr = '0, rf = '0, rr = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] left_speed, right_speed;
  logic [2:0] drive_mode;

  wall_follow_wheel_speed dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .front_center_mm(fc), .front_left_mm(fl), .front_right_mm(fr),
    .left_front_mm(lf), .left_rear_mm(lrr), .right_front_mm(rf),
    .right_rear_mm(rr),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_speed(left_speed), .right_speed(right_speed), .drive_mode(drive_mode)
  );

  // predictor state
  int unsigned vmax, vmin, obst, target, base, turn;
  longint prev_sq;

  speeds_t expected_speeds[$];
  int errors = 0;
  int results_seen = 0;
  int hold_cycles = 0;   // receiver hold-off, counted by the stall process
  bit rx_random = 1;

  initial forever #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic bit in_range(longint r);
    return r < vmax && r > vmin;
  endfunction

  function automatic longint fdiv(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic speeds_t steer(longint f_c, longint f_l, longint f_r,
                                    longint l_r, longint r_f, longint r_r);
    speeds_t s;
    longint c, full, num, den, lv, rv, diff, sq, dsq, n, tv;
    logic [2:0] m;
    full = longint'(base) << FB;
    if (!in_range(r_f)) begin
      c = CURV_NO_WALL;
      m = MODE_NO_WALL;
    end else begin
      diff = r_f - r_r;
      sq = diff * diff;
      if (r_f <= r_r) sq = -sq;
      dsq = sq - prev_sq;
      prev_sq = sq;
      n = 250 * (r_f + r_r - longint'(target)) + 30 * sq + 9 * dsq;
      c = fdiv(n * 256 + 5000, 10000);
      if (c > CURV_LIMIT) c = CURV_LIMIT;
      if (c < -CURV_LIMIT) c = -CURV_LIMIT;
      m = MODE_FOLLOW;
    end
    if (c > 0) begin
      num = 2560; den = 5120 - c;
    end else begin
      num = 2560 + c; den = 5120 + c;
    end
    lv = (full * num + den / 2) / den;
    rv = full - lv;
    if (in_range(f_c) && f_c < obst) begin
      tv = longint'(turn) << FB;
      if (in_range(f_l) && f_l < obst && in_range(f_r) && f_r < obst) begin
        lv = -(full / 2); rv = lv; m = MODE_REVERSE;
      end else if (!in_range(l_r) || l_r > r_r) begin
        lv = tv; rv = full - tv; m = MODE_TURN_L;
      end else begin
        rv = tv; lv = full - tv; m = MODE_TURN_R;
      end
    end
    s.left = clip16(lv);
    s.right = clip16(rv);
    s.mode = m;
    return s;
  endfunction

  // predict at acceptance
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      expected_speeds.push_back(steer(fc, fl, fr, lrr, rf, rr));
  end

  // result checker
  always @(posedge clk) begin
    speeds_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_speeds.size() == 0) begin
        errors++;
        $display("%0t unexpected beat: left %0d right %0d mode %0d", $time,
                 left_speed, right_speed, drive_mode);
      end else begin
        e = expected_speeds.pop_front();
        if (left_speed !== e.left) begin
          errors++;
          $display("%0t left_speed exp %0d got %0d", $time, e.left, left_speed);
        end
        if (right_speed !== e.right) begin
          errors++;
          $display("%0t right_speed exp %0d got %0d", $time, e.right, right_speed);
        end
        if (drive_mode !== e.mode) begin
          errors++;
          $display("%0t drive_mode exp %0d got %0d", $time, e.mode, drive_mode);
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    int w;
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1;
    end else if (rx_random && $urandom_range(0, 3) == 0) begin
      w = $urandom_range(0, 19);
      hold_cycles <= w;
      out_stall <= (w != 0);
    end else
      out_stall <= 0;
  end

  // valid stays high after a beat; the next gap or a drain drops it
  task automatic send_beat(input logic [DB-1:0] a, b, c, d, e, f, g, input int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    fc <= a; fl <= b; fr <= c; lf <= d; lrr <= e; rf <= f; rr <= g;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (expected_speeds.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int unsigned val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val[12:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      REG_VALID_MAX: vmax = val & 12'hFFF;
      REG_VALID_MIN: vmin = val & 12'hFFF;
      REG_OBSTACLE:  obst = val & 12'hFFF;
      REG_TARGET:    target = val & 13'h1FFF;
      REG_BASE:      base = val & 7'h7F;
      REG_TURN:      turn = val & 7'h7F;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_all(int unsigned mx, mn, ob, tg, bs, tn);
    wait_drained();
    write_reg(REG_VALID_MAX, mx);
    write_reg(REG_VALID_MIN, mn);
    write_reg(REG_OBSTACLE, ob);
    write_reg(REG_TARGET, tg);
    write_reg(REG_BASE, bs);
    write_reg(REG_TURN, tn);
  endtask

  function automatic logic [DB-1:0] pick_dist();
    case ($urandom_range(0, 5))
      0: return DB'($urandom);
      1: return DB'($urandom_range(0, 40));
      2: return DB'($urandom_range(4000, 4095));
      default: return DB'($urandom_range(0, vmax + 20 > 4095 ? 4095 : vmax + 20));
    endcase
  endfunction

  task automatic random_beats(int n, int maxgap);
    logic [DB-1:0] a, b, c, r1, r2;
    repeat (n) begin
      a = pick_dist(); b = pick_dist(); c = pick_dist(); r1 = pick_dist();
      r2 = ($urandom_range(0, 1)) ? DB'(r1 + $urandom_range(0, 30) - 15) : pick_dist();
      send_beat(a, b, c, pick_dist(), pick_dist(), r1, r2, $urandom_range(0, maxgap));
    end
  endtask

  task automatic test_directed();
    send_beat(0, 0, 0, 0, 0, 0, 0, 0);
    send_beat('1, '1, '1, '1, '1, '1, '1, 0);
    send_beat(500, 500, 500, 500, 500, 150, 150, 0);
    send_beat(500, 500, 500, 500, 500, 200, 100, 0);
    send_beat(500, 500, 500, 500, 500, 100, 200, 0);
    send_beat(500, 500, 500, 500, 500, 499, 21, 0);
    send_beat(500, 500, 500, 500, 500, 21, 499, 0);
    send_beat(500, 500, 500, 500, 500, 20, 100, 0);
    send_beat(500, 500, 500, 500, 500, 21, 21, 0);
    send_beat(100, 100, 100, 0, 0, 150, 150, 0);
    send_beat(100, 300, 100, 0, 300, 150, 200, 0);
    send_beat(100, 300, 100, 0, 100, 150, 200, 0);
    send_beat(100, 300, 100, 0, 100, 150, 100, 0);
    send_beat(21, 199, 21, 0, 0, 150, 150, 0);
    send_beat(199, 0, 100, 0, 0, 150, 150, 0);
    send_beat(200, 100, 100, 0, 0, 150, 150, 0);
    send_beat(12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 0);
    send_beat(12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 0);
  endtask

  task automatic test_settings();
    set_all(4095, 0, 4095, 8191, 127, 127);
    random_beats(150, 19);
    set_all(0, 4095, 0, 0, 0, 0);
    random_beats(30, 5);
    set_all(4095, 0, 300, 0, 127, 0);
    random_beats(150, 19);
    set_all(1000, 50, 400, 600, 1, 1);
    random_beats(150, 19);
    wait_drained();
    write_reg(3'd7, 13'h1FFF);
    write_reg(3'd6, 0);
  endtask

  task automatic test_backpressure();
    rx_random = 0;
    wait_drained();
    fork
      begin
        @(posedge clk);
        hold_cycles <= 300;
      end
      random_beats(20, 0);
    join
    rx_random = 1;
    wait_drained();
  endtask

  task automatic test_random();
    set_all(500, 20, 200, 300, 50, 10);
    random_beats(600, 19);
    random_beats(200, 0);
    set_all($urandom_range(100, 4095), $urandom_range(0, 80), $urandom_range(0, 800),
            $urandom_range(0, 8191), $urandom_range(0, 127), $urandom_range(0, 127));
    random_beats(600, 19);
  endtask

  initial begin
    vmax = 500; vmin = 20; obst = 200; target = 300; base = 50; turn = 10;
    prev_sq = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_settings();
    test_backpressure();
    test_random();
    wait_drained();
    $display("Checked %0d results over directed corners, six register settings,",
             results_seen);
    $display("backpressure fill and random readings with random idling.");
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire

>>> wall_follow_wheel_speed.f
rtl/wfws_pkg.sv
rtl/wfws_ctrl.sv
rtl/wfws_dp.sv
rtl/wall_follow_wheel_speed.sv
tb/sv/wall_follow_wheel_speed_tb.sv
